// ===== src/b64d_pkg.sv =====
// shared types, constants and the character map of the base64 decoder
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHR = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
  localparam logic [1:0] STATUS_SMALL   = 2'd3;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  localparam logic [5:0] LOWER_BASE   = 6'd26;
  localparam logic [5:0] DIGIT_BASE   = 6'd52;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic [1:0]  status;
    logic [15:0] byte_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  nbytes;
    logic        last;
    logic [1:0]  status;
    logic [15:0] count;
  } entry_t;

  // bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    case (c) inside
      [8'h41:8'h5A]: r = {1'b0, 6'(c - 8'h41)};
      [8'h61:8'h7A]: r = {1'b0, 6'(c - 8'h61) + LOWER_BASE};
      [8'h30:8'h39]: r = {1'b0, 6'(c - 8'h30) + DIGIT_BASE};
      8'h2B:         r = {1'b0, SEXTET_PLUS};
      8'h2F:         r = {1'b0, SEXTET_SLASH};
      PAD_CHAR:      r = 7'h00;
      default:       r = 7'h40;
    endcase
    return r;
  endfunction

endpackage

// ===== src/base64_decoder.sv =====
// top level of the streaming base64 decoder with its capacity register
//
//  channel   handshake          payload
//  input     push / full        item   (char_in, end_of_text)
//  result    pop / empty        result (data_byte, byte_valid, status, byte_count, last)
//  config    psel/penable/...   output_capacity at every paddr value
//
// one character is taken every cycle while the four-entry quad queue has room
// a quad yields up to three results, sent one per cycle from the output register while popped
// a result becomes visible once the output register loads it from the quad at the queue head
// full rises when the queue holds four quads that the result side has not drained
// synchronous reset clears message state and sets output_capacity to 65535
module base64_decoder import b64d_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  item_t       item,
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] output_capacity;
  logic        fire;
  logic        emit;
  entry_t      entry;
  entry_t      head;
  logic        head_empty;
  logic        head_pop;
  logic        q_full;

  assign pready = 1'b1;
  assign prdata = {16'h0000, output_capacity};
  assign full   = q_full;
  assign fire   = push && !q_full;

  // single register, every paddr value maps to it
  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready && (paddr[1:0] == paddr)) begin
      output_capacity <= pwdata[15:0];
    end
  end

  b64d_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (item),
    .capacity (output_capacity),
    .emit     (emit),
    .entry    (entry)
  );

  b64d_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fire && emit),
    .wdata (entry),
    .full  (q_full),
    .pop   (head_pop),
    .rdata (head),
    .empty (head_empty)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// ===== src/b64d_front.sv =====
// front end: character map, quad assembly, byte counting and status
module b64d_front import b64d_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  item_t       item,
  input  logic [15:0] capacity,
  output logic        emit,
  output entry_t      entry
);

  localparam int CW = COUNT_WIDTH;
  localparam int W  = (CW > 16) ? CW : 16;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  logic [17:0]   store;
  logic [1:0]    qpos;
  logic          third_pad;
  logic          err;
  logic [CW-1:0] bsf;

  logic [17:0]   store_next;
  logic [1:0]    qpos_next;
  logic          third_pad_next;
  logic          err_next;
  logic [CW-1:0] bsf_next;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [1:0] b);
    logic [CW+1:0] s;
    s = {2'b00, a} + {{CW{1'b0}}, b};
    return (s > {2'b00, COUNT_MAX}) ? COUNT_MAX : s[CW-1:0];
  endfunction

  always_comb begin
    logic [6:0]    sx;
    logic          pad;
    logic          err_now;
    logic [1:0]    k;
    logic [CW-1:0] idx1;
    logic [CW-1:0] idx2;
    logic [CW-1:0] total;
    logic [W-1:0]  cap_w;
    logic [W-1:0]  tot_w;
    logic          d0;
    logic          d1;
    logic          d2;
    sx      = sextet_of(item.char_in);
    pad     = (item.char_in == PAD_CHAR);
    err_now = err | sx[6];
    k       = 2'd3 - {1'b0, item.end_of_text & pad} - {1'b0, item.end_of_text & third_pad};
    idx1    = sat_add(bsf, 2'd1);
    idx2    = sat_add(bsf, 2'd2);
    total   = sat_add(bsf, k);
    cap_w   = W'(capacity);
    tot_w   = W'(total);
    d0      = !err_now && (k > 2'd0) && (W'(bsf) < cap_w);
    d1      = !err_now && (k > 2'd1) && (W'(idx1) < cap_w);
    d2      = !err_now && (k > 2'd2) && (W'(idx2) < cap_w);

    store_next     = store;
    qpos_next      = qpos;
    third_pad_next = third_pad;
    err_next       = err;
    bsf_next       = bsf;
    emit           = 1'b0;
    entry          = '0;

    if (qpos != 2'd3) begin
      store_next = {store[11:0], sx[5:0]};
      if (qpos == 2'd2) begin
        third_pad_next = pad;
      end
      qpos_next = qpos + 2'd1;
      err_next  = err_now;
      if (item.end_of_text) begin
        emit         = 1'b1;
        entry.last   = 1'b1;
        entry.status = STATUS_BAD_LEN;
        entry.count  = 16'(W'(bsf));
      end
    end else begin
      entry.triple   = {store, sx[5:0]};
      entry.nbytes   = {1'b0, d0} + {1'b0, d1} + {1'b0, d2};
      store_next     = '0;
      qpos_next      = 2'd0;
      third_pad_next = 1'b0;
      err_next       = err_now;
      bsf_next       = total;
      emit           = (entry.nbytes != 2'd0) || item.end_of_text;
      if (item.end_of_text) begin
        entry.last  = 1'b1;
        entry.count = tot_w[15:0];
        if (tot_w > cap_w) begin
          entry.status = STATUS_SMALL;
        end else if (err_now) begin
          entry.status = STATUS_BAD_CHR;
        end else begin
          entry.status = STATUS_OK;
        end
      end
    end

    if (item.end_of_text) begin
      store_next     = '0;
      qpos_next      = 2'd0;
      third_pad_next = 1'b0;
      err_next       = 1'b0;
      bsf_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store     <= '0;
      qpos      <= 2'd0;
      third_pad <= 1'b0;
      err       <= 1'b0;
      bsf       <= '0;
    end else if (fire) begin
      store     <= store_next;
      qpos      <= qpos_next;
      third_pad <= third_pad_next;
      err       <= err_next;
      bsf       <= bsf_next;
    end
  end

endmodule

// ===== src/b64d_queue.sv =====
// short queue of decoded quads between front end and result sequencer
module b64d_queue import b64d_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output entry_t rdata,
  output logic   empty
);

  entry_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wptr;
  logic [QUEUE_PTR_W-1:0] rptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full  = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a write");
`endif

endmodule

// ===== src/b64d_back.sv =====
// result sequencer: splits each quad into byte transfers behind an output register
module b64d_back import b64d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  entry_t  head,
  input  logic    head_empty,
  output logic    head_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  logic [1:0] sub;
  logic [1:0] last_sub;
  logic       out_valid;
  logic       load;
  result_t    res_next;

  assign last_sub = (head.nbytes == 2'd0) ? 2'd0 : head.nbytes - 2'd1;
  assign load     = !head_empty && (!out_valid || pop);
  assign head_pop = load && (sub == last_sub);
  assign empty    = !out_valid;

  always_comb begin
    res_next = '0;
    if (head.nbytes != 2'd0) begin
      res_next.byte_valid = 1'b1;
      case (sub)
        2'd0:    res_next.data_byte = head.triple[23:16];
        2'd1:    res_next.data_byte = head.triple[15:8];
        default: res_next.data_byte = head.triple[7:0];
      endcase
    end
    if (head.last && (sub == last_sub)) begin
      res_next.last       = 1'b1;
      res_next.status     = head.status;
      res_next.byte_count = head.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      sub       <= (sub == last_sub) ? 2'd0 : sub + 2'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

endmodule

// ===== tb/sv/tb_base64_decoder.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the streaming base64 decoder with its capacity register
module tb_base64_decoder;
  import b64d_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT = 38;
  localparam int COUNT_MAX = 65535;
  localparam int PHASE_CHARS = 70;
  localparam logic [1:0] CAPACITY_ADDR = 2'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  item_t       item = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = CAPACITY_ADDR;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // decoder state as the block should hold it
  logic [17:0] sextets = '0;
  int          quad_pos = 0;
  bit          third_pad = 1'b0;
  bit          bad_char = 1'b0;
  int          decoded_count = 0;
  int          capacity = COUNT_MAX;

  result_t     decoded_q[$];
  bit          steady = 1'b0;
  bit          pause_pending = 1'b1;
  int          errors = 0;
  int          chars_sent = 0;
  int          messages_done = 0;
  int          results_checked = 0;
  int          stall_cycles = 0;

  base64_decoder #(.COUNT_WIDTH(16)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // bit 6 flags a character outside the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};
    if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};
    if (c == 8'h2B) return 7'd62;
    if (c == 8'h2F) return 7'd63;
    if (c == PAD_CHAR) return 7'd0;
    return 7'h40;
  endfunction

  function automatic logic [7:0] sextet_char(input int v);
    if (v < 26) return 8'(v + 8'h41);
    if (v < 52) return 8'(v - 26 + 8'h61);
    if (v < 62) return 8'(v - 52 + 8'h30);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic void clear_message();
    sextets = '0;
    quad_pos = 0;
    third_pad = 1'b0;
    bad_char = 1'b0;
    decoded_count = 0;
  endfunction

  function automatic void decode_step(input logic [7:0] c, input logic eot);
    logic [6:0]  sx;
    logic [23:0] triple;
    logic [1:0]  st;
    result_t     r;
    int          nbytes;
    int          delivered;
    sx = char_sextet(c);
    if (sx[6]) bad_char = 1'b1;
    delivered = 0;
    if (eot) messages_done++;
    if (quad_pos < 3) begin
      sextets = {sextets[11:0], sx[5:0]};
      if (quad_pos == 2) third_pad = (c == PAD_CHAR);
      quad_pos++;
      if (eot) begin
        decoded_q.push_back('{data_byte: 8'd0, byte_valid: 1'b0, status: STATUS_BAD_LEN,
                              byte_count: 16'(decoded_count), last: 1'b1});
        clear_message();
      end
      return;
    end
    triple = {sextets, sx[5:0]};
    nbytes = 3;
    if (eot) begin
      if (c == PAD_CHAR) nbytes--;
      if (third_pad) nbytes--;
    end
    for (int i = 0; i < nbytes; i++) begin
      if (!bad_char && decoded_count < capacity) begin
        decoded_q.push_back('{data_byte: triple[23 - 8 * i -: 8], byte_valid: 1'b1,
                              status: STATUS_OK, byte_count: 16'd0, last: 1'b0});
        delivered++;
      end
      if (decoded_count < COUNT_MAX) decoded_count++;
    end
    sextets = '0;
    quad_pos = 0;
    third_pad = 1'b0;
    if (eot) begin
      if (decoded_count > capacity) st = STATUS_SMALL;
      else if (bad_char) st = STATUS_BAD_CHR;
      else st = STATUS_OK;
      if (delivered == 0)
        decoded_q.push_back('{data_byte: 8'd0, byte_valid: 1'b0, status: STATUS_OK,
                              byte_count: 16'd0, last: 1'b0});
      r = decoded_q[decoded_q.size() - 1];
      r.status = st;
      r.byte_count = 16'(decoded_count);
      r.last = 1'b1;
      decoded_q[decoded_q.size() - 1] = r;
      clear_message();
    end
  endfunction

  task automatic flag_field(input string name, input int want_v, input int got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
  endtask

  // result side: check every transfer, stall pop at random outside the steady phase
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      results_checked++;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, result);
      end else begin
        want = decoded_q.pop_front();
        if (result.data_byte !== want.data_byte)
          flag_field("data_byte", want.data_byte, result.data_byte);
        if (result.byte_valid !== want.byte_valid)
          flag_field("byte_valid", want.byte_valid, result.byte_valid);
        if (result.status !== want.status)
          flag_field("status", want.status, result.status);
        if (result.byte_count !== want.byte_count)
          flag_field("byte_count", want.byte_count, result.byte_count);
        if (result.last !== want.last)
          flag_field("last", want.last, result.last);
      end
    end
    pop <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || psel) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, decoded_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] c, input logic eot);
    if (!steady)
      while ($urandom_range(99) < IDLE_PCT) begin
        push <= 1'b0;
        @(posedge clk);
      end
    push <= 1'b1;
    item <= '{char_in: c, end_of_text: eot};
    do @(posedge clk); while (full);
    decode_step(c, eot);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained(input bit settle);
    push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    capacity = value;
    // read back right after the write
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0, value}) begin
      errors++;
      $display("%0t: capacity readback, expected %0d, got %0d", $time, value, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_alphabet_and_padding();
    send_text("AZaz09+/");
    // pad chars in a non-final quad and in the first positions are plain zeros
    send_text("=/A==A==");
    send_text("//8=");
    wait_drained(1'b1);
  endtask

  task automatic test_invalid_and_length();
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(PAD_CHAR, 1'b1);
    send_text("ABC");
    send_text("Z");
    wait_drained(1'b1);
  endtask

  task automatic test_capacity_limits();
    write_capacity(16'd1);
    send_text("TWFu");
    wait_drained(1'b1);
    write_capacity(16'd0);
    send_text("TQ==");
    wait_drained(1'b1);
  endtask

  task automatic test_random_messages();
    logic [7:0] msg[$];
    int caps[5];
    int phase_start;
    int nq;
    int kind;
    int pause_at;
    caps[0] = COUNT_MAX;
    caps[1] = 0;
    caps[2] = $urandom_range(1, 12);
    caps[3] = $urandom_range(13, 40);
    caps[4] = COUNT_MAX;
    for (int p = 0; p < 5; p++) begin
      write_capacity(16'(caps[p]));
      steady = (p == 2);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        msg.delete();
        kind = $urandom_range(99);
        if (kind < 88) begin
          nq = $urandom_range(1, 4);
          for (int i = 0; i < nq * 4; i++)
            msg.push_back($urandom_range(15) == 0 ? PAD_CHAR : sextet_char($urandom_range(63)));
          case ($urandom_range(2))
            1: msg[msg.size() - 1] = PAD_CHAR;
            2: begin
              msg[msg.size() - 1] = PAD_CHAR;
              msg[msg.size() - 2] = PAD_CHAR;
            end
            default: ;
          endcase
          if (kind >= 70 && kind < 80)
            msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
          if (kind >= 80)
            repeat ($urandom_range(1, 3)) void'(msg.pop_back());
        end else begin
          repeat ($urandom_range(1, 9)) msg.push_back(8'($urandom_range(255)));
        end
        pause_at = -1;
        if (pause_pending && p == 1 && msg.size() > 1) begin
          pause_at = msg.size() / 2;
          pause_pending = 1'b0;
        end else if ($urandom_range(24) == 0) begin
          pause_at = $urandom_range(msg.size() - 1);
        end
        for (int i = 0; i < msg.size(); i++) begin
          if (i == pause_at) wait_drained(1'b0);
          send_item(msg[i], i == msg.size() - 1);
        end
      end
      steady = 1'b0;
      wait_drained(1'b1);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_alphabet_and_padding();
    test_invalid_and_length();
    test_capacity_limits();
    test_random_messages();
    $display("covered %0d characters in %0d messages, %0d results checked",
             chars_sent, messages_done, results_checked);
    $display("capacities 0, 1, 65535 and random, padding, bad chars, bad length");
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_decoder.sv
tb/sv/tb_base64_decoder.sv
